// ----- hw/rtl/set_assoc_cache_lru_tags_unit_macros.svh -----
// Assertion macros used by the cache tag unit checker.
`ifndef SET_ASSOC_CACHE_LRU_TAGS_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SAC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sac assertion failed");

// Next-cycle implication, disabled during reset.
`define SAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sac assertion failed");

`endif

// ----- hw/rtl/sac_pkg.sv -----
// Package: sizes, register codes and controller/datapath types of the cache tag unit.
package sac_pkg;

   localparam int MAX_SETS  = 1024;
   localparam int MAX_WAYS  = 8;
   localparam int ADDR_BITS = 32;

   localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
   localparam int TAG_W    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int CFG_W    = 4;
   localparam int CIDX_W   = 2;
   localparam int CNT_W    = 32;
   localparam int SHIFT_W  = CFG_W + 1;

   localparam logic [CFG_W-1:0] OFFSET_LIMIT = CFG_W'(12);
   localparam logic [CFG_W-1:0] INDEX_LIMIT  = CFG_W'(10);
   localparam logic [CFG_W-1:0] OFFSET_RESET = CFG_W'(6);
   localparam logic [CFG_W-1:0] INDEX_RESET  = CFG_W'(4);
   localparam logic [CFG_W-1:0] WAYS_RESET   = CFG_W'(1);

   // Configuration register indexes
   localparam logic [CIDX_W-1:0] REG_OFFSET_BITS = CIDX_W'(0);
   localparam logic [CIDX_W-1:0] REG_INDEX_BITS  = CIDX_W'(1);
   localparam logic [CIDX_W-1:0] REG_WAYS_IN_USE = CIDX_W'(2);

   // Per-set recency ranks and valid bits, kept in one RAM row
   typedef struct packed {
      logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
      logic [MAX_WAYS-1:0]             valid;
   } meta_type;

   localparam int META_W    = $bits(meta_type);
   localparam int TAG_ROW_W = MAX_WAYS * TAG_W;

   typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic lookup;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
   } ctrl_status_type;

endpackage

// ----- hw/rtl/sac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/sac_ctrl.sv -----
// Controller: clearing pass after reset, then accept, lookup and result strobe.
module sac_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   output sac_pkg::ctrl_cmd_type    cmd,
   input  sac_pkg::ctrl_status_type status
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.accept   = (state_ff == ST_IDLE) && start;
      cmd.lookup   = (state_ff == ST_LOOKUP);
   end

   // Strobe the result in the cycle after the lookup
   assign rsp_valid_in = (state_ff == ST_LOOKUP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/sac_datapath.sv -----
// Datapath: config registers, address split, tag and LRU RAMs, compare, victim pick, counters.
module sac_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sac_pkg::ctrl_cmd_type                cmd,
   output sac_pkg::ctrl_status_type             status,
   input  logic                                 csr_wr,
   input  logic [sac_pkg::CIDX_W-1:0]           csr_index,
   input  logic [sac_pkg::CFG_W-1:0]            csr_data,
   input  logic [sac_pkg::ADDR_BITS-1:0]        req_address,
   output logic                                 rsp_hit,
   output logic [sac_pkg::WAY_W-1:0]            rsp_way,
   output logic [sac_pkg::CNT_W-1:0]            rsp_hit_count,
   output logic [sac_pkg::CNT_W-1:0]            rsp_miss_count
);

   logic [sac_pkg::CFG_W-1:0]     offset_ff, index_ff, ways_ff;
   logic [sac_pkg::CFG_W-1:0]     off_eff, idx_eff;
   logic [sac_pkg::WCNT_W-1:0]    ways_eff;
   logic [sac_pkg::SHIFT_W-1:0]   tag_shift;
   logic [sac_pkg::ADDR_BITS-1:0] addr_shift;
   logic [sac_pkg::ADDR_BITS-1:0] addr_tag;
   logic [sac_pkg::SET_W-1:0]     set_rd;
   logic [sac_pkg::SET_W-1:0]     set_ff;
   logic [sac_pkg::TAG_W-1:0]     tag_ff;
   logic [sac_pkg::SET_W-1:0]     clear_cnt_ff, clear_cnt_in;

   logic [sac_pkg::TAG_ROW_W-1:0] tag_rdata, tag_wdata;
   logic [sac_pkg::META_W-1:0]    meta_rdata, meta_wdata;
   logic [sac_pkg::SET_W-1:0]     meta_waddr;
   logic                          tag_we, meta_we;

   sac_pkg::tag_row_type          tag_row, tag_row_new;
   sac_pkg::meta_type             meta_rd, meta_new, meta_clear;

   logic                          hit;
   logic [sac_pkg::WAY_W-1:0]     hit_way, vic_way, chosen;
   logic [sac_pkg::RANK_W:0]      best;
   logic [sac_pkg::RANK_W-1:0]    old_rank;

   logic                          hit_ff;
   logic [sac_pkg::WAY_W-1:0]     way_ff;
   logic [sac_pkg::CNT_W-1:0]     hits_ff, hits_in, misses_ff, misses_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= sac_pkg::OFFSET_RESET;
         index_ff  <= sac_pkg::INDEX_RESET;
         ways_ff   <= sac_pkg::WAYS_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            sac_pkg::REG_OFFSET_BITS: offset_ff <= csr_data;
            sac_pkg::REG_INDEX_BITS:  index_ff  <= csr_data;
            sac_pkg::REG_WAYS_IN_USE: ways_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Clamp the configuration to its legal range
   always_comb begin
      off_eff = (offset_ff > sac_pkg::OFFSET_LIMIT) ? sac_pkg::OFFSET_LIMIT : offset_ff;
      idx_eff = (index_ff > sac_pkg::INDEX_LIMIT) ? sac_pkg::INDEX_LIMIT : index_ff;
      if (ways_ff == '0) begin
         ways_eff = sac_pkg::WCNT_W'(1);
      end else if (int'(ways_ff) > sac_pkg::MAX_WAYS) begin
         ways_eff = sac_pkg::WCNT_W'(sac_pkg::MAX_WAYS);
      end else begin
         ways_eff = sac_pkg::WCNT_W'(ways_ff);
      end
   end

   // Split the incoming address into set and tag
   always_comb begin
      addr_shift = req_address >> off_eff;
      tag_shift  = {1'b0, off_eff} + {1'b0, idx_eff};
      addr_tag   = req_address >> tag_shift;
      for (int i = 0; i < sac_pkg::SET_W; i++) begin
         set_rd[i] = addr_shift[i] & (int'(idx_eff) > i);
      end
   end

   // Hold set and tag of the accepted item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         set_ff <= set_rd;
         tag_ff <= addr_tag[sac_pkg::TAG_W-1:0];
      end
   end

   // Clearing pass counter
   assign clear_cnt_in      = clear_cnt_ff + sac_pkg::SET_W'(1);
   assign status.clear_last = (int'(clear_cnt_ff) == sac_pkg::MAX_SETS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Tag and metadata stores, read with the address of the item being accepted
   sac_ram #(
      .WIDTH (sac_pkg::TAG_ROW_W),
      .DEPTH (sac_pkg::MAX_SETS)
   ) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (set_ff),
      .wdata (tag_wdata),
      .raddr (set_rd),
      .rdata (tag_rdata)
   );

   sac_ram #(
      .WIDTH (sac_pkg::META_W),
      .DEPTH (sac_pkg::MAX_SETS)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .raddr (set_rd),
      .rdata (meta_rdata)
   );

   assign tag_row = sac_pkg::tag_row_type'(tag_rdata);
   assign meta_rd = sac_pkg::meta_type'(meta_rdata);

   // Compare against valid ways in use; lowest matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = sac_pkg::MAX_WAYS - 1; w >= 0; w--) begin
         if ((int'(ways_eff) > w) && meta_rd.valid[w] && (tag_row[w] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = sac_pkg::WAY_W'(w);
         end
      end
   end

   // Pick the oldest way in use as victim
   always_comb begin
      best    = '1;
      vic_way = '0;
      for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
         if ((int'(ways_eff) > w) && ({1'b0, meta_rd.rank[w]} < best)) begin
            best    = {1'b0, meta_rd.rank[w]};
            vic_way = sac_pkg::WAY_W'(w);
         end
      end
   end

   // Make the chosen way newest; ways ranked above it move down
   always_comb begin
      chosen   = hit ? hit_way : vic_way;
      old_rank = meta_rd.rank[chosen];
      meta_new = meta_rd;
      for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
         if (meta_rd.rank[w] > old_rank) begin
            meta_new.rank[w] = meta_rd.rank[w] - sac_pkg::RANK_W'(1);
         end
      end
      meta_new.rank[chosen]  = sac_pkg::RANK_W'(sac_pkg::MAX_WAYS - 1);
      meta_new.valid[chosen] = 1'b1;

      tag_row_new         = tag_row;
      tag_row_new[chosen] = tag_ff;
   end

   // Reset row: nothing valid, way i has rank i
   always_comb begin
      meta_clear.valid = '0;
      for (int w = 0; w < sac_pkg::MAX_WAYS; w++) begin
         meta_clear.rank[w] = sac_pkg::RANK_W'(w);
      end
   end

   // Write back
   assign tag_we     = cmd.lookup && !hit;
   assign tag_wdata  = sac_pkg::TAG_ROW_W'(tag_row_new);
   assign meta_we    = cmd.lookup || cmd.clear_wr;
   assign meta_waddr = cmd.clear_wr ? clear_cnt_ff : set_ff;
   assign meta_wdata = cmd.clear_wr ? sac_pkg::META_W'(meta_clear) : sac_pkg::META_W'(meta_new);

   // Saturating hit and miss totals
   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      if (hit) begin
         if (hits_ff != '1) begin
            hits_in = hits_ff + sac_pkg::CNT_W'(1);
         end
      end else if (misses_ff != '1) begin
         misses_in = misses_ff + sac_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (cmd.lookup) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff <= hit;
         way_ff <= chosen;
      end
   end

   assign rsp_hit        = hit_ff;
   assign rsp_way        = way_ff;
   assign rsp_hit_count  = hits_ff;
   assign rsp_miss_count = misses_ff;

endmodule

// ----- hw/rtl/set_assoc_cache_lru_tags_unit.sv -----
// Top level of the set-associative cache tag unit with true LRU replacement.
//
//   channel   handshake                 payload
//   request   start / busy              req_address
//   result    rsp_valid (strobe)        rsp_hit, rsp_way, rsp_hit_count, rsp_miss_count
//   config    csr_valid / csr_ready     csr_index, csr_data
//
// Each address passes an accept cycle, which issues the set read to the tag and metadata
// RAMs (registered read), and a lookup cycle, which compares, picks and writes the row back.
// The result strobes for one cycle after the lookup, while the next address may be accepted.
// After reset a clearing pass writes all MAX_SETS (1024) rows of the LRU/valid RAM; busy
// stays high meanwhile. Configuration writes are always taken. Results cannot be stalled.
module set_assoc_cache_lru_tags_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sac_pkg::ADDR_BITS-1:0]   req_address,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [sac_pkg::WAY_W-1:0]       rsp_way,
   output logic [sac_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [sac_pkg::CNT_W-1:0]       rsp_miss_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sac_pkg::CIDX_W-1:0]      csr_index,
   input  logic [sac_pkg::CFG_W-1:0]       csr_data
);

   sac_pkg::ctrl_cmd_type    cmd;
   sac_pkg::ctrl_status_type status;

   // Register writes are never held off
   assign csr_ready = 1'b1;

   sac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   sac_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_address    (req_address),
      .rsp_hit        (rsp_hit),
      .rsp_way        (rsp_way),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

endmodule

// ----- hw/rtl/sac_checker.sv -----
// Port-level checker for the cache tag unit, bound to the top level.
`include "set_assoc_cache_lru_tags_unit_macros.svh"

module sac_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic                            rsp_hit,
   input logic [sac_pkg::CNT_W-1:0]       rsp_hit_count,
   input logic [sac_pkg::CNT_W-1:0]       rsp_miss_count
);

   // An accepted transfer occupies the unit for the lookup cycle, then strobes its result
   `SAC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SAC_ASSERT_NEXT(a_accept_result, clock, reset, start && !busy, ##1 rsp_valid)

   // A result is shown only while the unit is ready again, and lasts one cycle
   `SAC_ASSERT_SAME(a_result_idle, clock, reset, rsp_valid, !busy)
   `SAC_ASSERT_NEXT(a_result_once, clock, reset, rsp_valid, !rsp_valid)

   // The total matching the outcome has counted it
   `SAC_ASSERT_SAME(a_count_nonzero, clock, reset, rsp_valid,
                    (rsp_hit && rsp_hit_count != '0) || (!rsp_hit && rsp_miss_count != '0))

endmodule

bind set_assoc_cache_lru_tags_unit sac_checker u_sac_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_hit_count  (rsp_hit_count),
   .rsp_miss_count (rsp_miss_count)
);
